@@ hw/rtl/owb_pkg.sv @@
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants of the one-wire bus master: command codes,
// sequencer phases, queued tick word and configuration register map.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int unsigned CfgCount   = 8;
    localparam int unsigned CfgWidth   = 10;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CountWidth = 11;
    localparam int unsigned ReadTailUs = 53;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_SLOT    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd7;

    localparam logic [CfgWidth-1:0] CfgResetVals [CfgCount] = '{
        10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd70, 10'd3, 10'd10
    };

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_WBYTE = 3'd2,
        CMD_RBYTE = 3'd3,
        CMD_WBIT  = 3'd4,
        CMD_RBIT  = 3'd5
    } t_cmd;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_RST_TAIL = 8'b0000_1000,
        PH_WR_LOW   = 8'b0001_0000,
        PH_WR_REL   = 8'b0010_0000,
        PH_RD_LOW   = 8'b0100_0000,
        PH_RD_REL   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       line;
    } t_tick;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_queue_head;

    function automatic logic [CfgWidth-1:0] at_least_one(input logic [CfgWidth-1:0] v);
        return (v == '0) ? CfgWidth'(1) : v;
    endfunction

endpackage

@@ hw/rtl/owb_if.sv @@
// ----------------------------------------------------------------------------
// owb_in_if / owb_out_if
// Valid/ready channels for microsecond ticks in and bus results out.
// ----------------------------------------------------------------------------
interface owb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output mode, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_level,
                    output ready);
endinterface

interface owb_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, output ready);
endinterface

@@ hw/rtl/owb_front.sv @@
// ----------------------------------------------------------------------------
// owb_front
// Accepts tick words, decodes the mode field into a command and queues the
// tick for the bus sequencer.
// ----------------------------------------------------------------------------
module owb_front
    import owb_pkg::*;
#(
    parameter int unsigned Depth = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    owb_in_if.sink        i_in_ch,
    input  logic          i_pop,
    output t_queue_head   o_head
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_tick           r_q [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            pop;
    t_tick           in_tick;

    always_comb begin
        unique case (i_in_ch.mode)
            CMD_RESET: in_tick.cmd = CMD_RESET;
            CMD_WBYTE: in_tick.cmd = CMD_WBYTE;
            CMD_RBYTE: in_tick.cmd = CMD_RBYTE;
            CMD_WBIT:  in_tick.cmd = CMD_WBIT;
            CMD_RBIT:  in_tick.cmd = CMD_RBIT;
            default:   in_tick.cmd = CMD_NONE;
        endcase
        in_tick.data = i_in_ch.data_byte;
        in_tick.line = i_in_ch.line_level;
    end

    assign i_in_ch.ready = (r_cnt != FullCnt);
    assign push          = i_in_ch.valid && i_in_ch.ready;
    assign pop           = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.tick  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_tick;
        end
    end

endmodule

@@ hw/rtl/owb_engine.sv @@
// ----------------------------------------------------------------------------
// owb_engine
// Bus sequencer: holds the slot timing registers, advances reset, write and
// read slots by one microsecond per queued tick and registers each result.
// ----------------------------------------------------------------------------
module owb_engine
    import owb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgWidth-1:0] i_cfg_data,
    input  t_queue_head         i_head,
    output logic                o_pop,
    owb_out_if.source           o_out_ch
);

    logic [CfgWidth-1:0]   r_cfg [CfgCount];
    t_phase                r_phase, s_phase, n_phase;
    logic [CountWidth-1:0] r_count, s_count, n_count;
    logic [3:0]            r_bit_cnt, s_bit_cnt, n_bit_cnt;
    logic [7:0]            r_shift, s_shift, n_shift;
    t_cmd                  r_cmd, s_cmd;
    logic                  r_presence, n_presence;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic [CountWidth-1:0] cnt_inc;
    logic                  wr_bit;
    logic [CfgWidth-1:0]   wr_low;
    logic [CfgWidth-1:0]   wr_rel;
    logic [CfgWidth-1:0]   rd_len;
    logic [3:0]            slot_next;
    logic                  slot_more;
    logic                  done;

    assign o_pop = i_head.valid && (!r_out_valid || o_out_ch.ready);

    // apply a command that arrives while idle
    always_comb begin
        s_phase   = r_phase;
        s_count   = r_count;
        s_bit_cnt = r_bit_cnt;
        s_shift   = r_shift;
        s_cmd     = r_cmd;
        if (r_phase == PH_IDLE && i_head.tick.cmd != CMD_NONE) begin
            s_cmd     = i_head.tick.cmd;
            s_count   = '0;
            s_bit_cnt = '0;
            unique case (i_head.tick.cmd)
                CMD_RESET: begin
                    s_phase = PH_RST_LOW;
                end
                CMD_WBYTE, CMD_WBIT: begin
                    s_phase = PH_WR_LOW;
                    s_shift = i_head.tick.data;
                end
                default: begin
                    s_phase = PH_RD_LOW;
                    s_shift = '0;
                end
            endcase
        end
    end

    always_comb begin
        cnt_inc   = s_count + CountWidth'(1);
        wr_bit    = (s_cmd == CMD_WBYTE) ? s_shift[s_bit_cnt[2:0]] : s_shift[0];
        wr_low    = at_least_one(wr_bit ? r_cfg[CFG_WRITE_ONE_LOW]
                                        : r_cfg[CFG_WRITE_ZERO_LOW]);
        wr_rel    = (r_cfg[CFG_WRITE_SLOT] > wr_low) ? r_cfg[CFG_WRITE_SLOT] - wr_low : '0;
        rd_len    = at_least_one(r_cfg[CFG_READ_SAMPLE]);
        slot_next = s_bit_cnt + 4'd1;
        slot_more = (s_cmd == CMD_WBYTE || s_cmd == CMD_RBYTE) && (slot_next < 4'd8);

        n_phase    = s_phase;
        n_count    = cnt_inc;
        n_bit_cnt  = s_bit_cnt;
        n_shift    = s_shift;
        n_presence = r_presence;
        done       = 1'b0;

        unique case (s_phase)
            PH_IDLE: begin
                n_count = s_count;
            end
            PH_RST_LOW: begin
                if (cnt_inc >= {1'b0, at_least_one(r_cfg[CFG_RESET_LOW])}) begin
                    n_phase = PH_RST_WAIT;
                    n_count = '0;
                end
            end
            PH_RST_WAIT: begin
                if (cnt_inc >= {1'b0, at_least_one(r_cfg[CFG_PRESENCE_WAIT])}) begin
                    n_phase = PH_RST_TAIL;
                    n_count = '0;
                end
            end
            PH_RST_TAIL: begin
                if (s_count == '0) begin
                    n_presence = ~i_head.tick.line;
                end
                if (cnt_inc >= {1'b0, at_least_one(r_cfg[CFG_RESET_TAIL])}) begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                    done    = 1'b1;
                end
            end
            PH_WR_LOW: begin
                if (cnt_inc >= {1'b0, wr_low}) begin
                    n_count = '0;
                    if (wr_rel == '0) begin
                        n_bit_cnt = slot_next;
                        done      = !slot_more;
                        n_phase   = slot_more ? PH_WR_LOW : PH_IDLE;
                    end else begin
                        n_phase = PH_WR_REL;
                    end
                end
            end
            PH_WR_REL: begin
                if (cnt_inc >= {1'b0, wr_rel}) begin
                    n_count   = '0;
                    n_bit_cnt = slot_next;
                    done      = !slot_more;
                    n_phase   = slot_more ? PH_WR_LOW : PH_IDLE;
                end
            end
            PH_RD_LOW: begin
                if (cnt_inc >= {1'b0, at_least_one(r_cfg[CFG_READ_LOW])}) begin
                    n_phase = PH_RD_REL;
                    n_count = '0;
                end
            end
            PH_RD_REL: begin
                // sample on the first tick of the fixed tail
                if (s_count == {1'b0, rd_len}) begin
                    n_shift = (s_cmd == CMD_RBYTE) ? {i_head.tick.line, s_shift[7:1]}
                                                   : {7'd0, i_head.tick.line};
                end
                if (cnt_inc >= {1'b0, rd_len} + CountWidth'(ReadTailUs)) begin
                    n_count   = '0;
                    n_bit_cnt = slot_next;
                    done      = !slot_more;
                    n_phase   = slot_more ? PH_RD_LOW : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase

        n_out.drive_low = (s_phase == PH_RST_LOW) || (s_phase == PH_WR_LOW) ||
                          (s_phase == PH_RD_LOW);
        n_out.busy_res  = (s_phase != PH_IDLE);
        n_out.done_res  = done;
        n_out.presence  = n_presence;
        n_out.read_data = (s_cmd == CMD_RBYTE || s_cmd == CMD_RBIT) ? n_shift : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CfgResetVals;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_cmd       <= CMD_NONE;
            r_presence  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            if (o_pop) begin
                r_phase    <= n_phase;
                r_count    <= n_count;
                r_bit_cnt  <= n_bit_cnt;
                r_shift    <= n_shift;
                r_cmd      <= s_cmd;
                r_presence <= n_presence;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.drive_low = r_out.drive_low;
    assign o_out_ch.busy_res  = r_out.busy_res;
    assign o_out_ch.done_res  = r_out.done_res;
    assign o_out_ch.presence  = r_out.presence;
    assign o_out_ch.read_data = r_out.read_data;

endmodule

@@ hw/rtl/one_wire_bus_master_top.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// One-wire bus master advanced by one tick word per microsecond; produces
// one result word (drive level, busy, done, presence, read data) per tick.
//
//   channel    dir   word                                       handshake
//   i_in_ch    in    mode, data_byte, line_level                valid/ready
//   o_out_ch   out   drive_low, busy_res, done_res, presence,   valid/ready
//                    read_data
//   i_cfg_*    in    8 x 10-bit slot timing registers           write enable
//
// One tick word per cycle sustained while the result side is ready; its result
// word is offered once the tick has passed the tick queue and then the sequencer
// step into the result register.
// Reset clears the queue, the sequencer and loads the default timings.
// A stall at the output holds the result register; the queue keeps
// accepting until it holds QueueDepth words.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top
    import owb_pkg::*;
#(
    parameter int unsigned QueueDepth = 2  // at least 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgWidth-1:0] i_cfg_data,
    owb_in_if.sink              i_in_ch,
    owb_out_if.source           o_out_ch
);

    t_queue_head head;
    logic        pop;

    owb_front #(
        .Depth (QueueDepth)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_pop   (pop),
        .o_head  (head)
    );

    owb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_ch    (o_out_ch)
    );

endmodule

@@ tb/one_wire_bus_master_top_test.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_test
// Self-checking bench for the one-wire bus master. Microsecond tick words go
// in over valid/ready, and a tick-level model of the reset, write and read
// slot sequencer predicts every result word, which is compared field by field.
// Slot timings are reprogrammed between commands and in the middle of them.
// Both channels idle at random, and the result side is held off for a while.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_test
    import owb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int unsigned DrainSlack  = 4;
    localparam int unsigned RandomTicks = 60;
    localparam int unsigned HoldOffCycles = 200;

    // mode codes outside the command set; the block treats them as plain ticks
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        LINE_LOW,
        LINE_HIGH,
        LINE_NOISY
    } t_line_style;

    typedef logic [CfgWidth-1:0] t_timing_set [CfgCount];

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgWidth-1:0] i_cfg_data;

    owb_in_if  in_ch ();
    owb_out_if out_ch ();

    one_wire_bus_master_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer model
    // ------------------------------------------------------------------
    t_phase              bus_phase;
    int unsigned         slot_count;
    int unsigned         bit_index;
    logic [7:0]          shift_byte;
    logic [2:0]          active_cmd;
    logic                presence_seen;
    logic [CfgWidth-1:0] timing_us [CfgCount];

    t_result     pending_results [$];
    int unsigned ticks_sent;
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          steady_flow;
    int unsigned holdoff_req;

    function automatic void reset_bus_model();
        bus_phase     = PH_IDLE;
        slot_count    = 0;
        bit_index     = 0;
        shift_byte    = '0;
        active_cmd    = CMD_NONE;
        presence_seen = 1'b0;
        for (int i = 0; i < CfgCount; i++) timing_us[i] = CfgResetVals[i];
    endfunction

    function automatic int unsigned us_floor1(input logic [CfgWidth-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned tx_low_us();
        logic bit_val;
        bit_val = (active_cmd == CMD_WBYTE) ? shift_byte[bit_index % 8] : shift_byte[0];
        return us_floor1(bit_val ? timing_us[CFG_WRITE_ONE_LOW] : timing_us[CFG_WRITE_ZERO_LOW]);
    endfunction

    function automatic int unsigned tx_release_us();
        int unsigned low;
        int unsigned slot;
        low  = tx_low_us();
        slot = timing_us[CFG_WRITE_SLOT];
        return (slot > low) ? slot - low : 0;
    endfunction

    // Close one bit slot; return 1 when the whole command is over.
    function automatic logic close_slot();
        slot_count = 0;
        bit_index  = (bit_index + 1) & 15;
        if ((active_cmd == CMD_WBYTE || active_cmd == CMD_RBYTE) && bit_index < 8) begin
            if (active_cmd == CMD_WBYTE) bus_phase = PH_WR_LOW;
            else bus_phase = PH_RD_LOW;
            return 1'b0;
        end
        bus_phase = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic t_result predict_bus_tick(input logic [2:0] mode, input logic [7:0] data,
                                                 input logic line);
        t_result     res;
        int unsigned span;
        logic        done;
        done = 1'b0;
        if (bus_phase == PH_IDLE && mode >= CMD_RESET && mode <= CMD_RBIT) begin
            active_cmd = mode;
            slot_count = 0;
            bit_index  = 0;
            if (mode == CMD_RESET) begin
                bus_phase = PH_RST_LOW;
            end else if (mode == CMD_WBYTE || mode == CMD_WBIT) begin
                shift_byte = data;
                bus_phase  = PH_WR_LOW;
            end else begin
                shift_byte = '0;
                bus_phase  = PH_RD_LOW;
            end
        end

        res.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                        (bus_phase == PH_RD_LOW);
        res.busy_res  = (bus_phase != PH_IDLE);

        case (bus_phase)
            PH_RST_LOW: begin
                slot_count++;
                if (slot_count >= us_floor1(timing_us[CFG_RESET_LOW])) begin
                    bus_phase  = PH_RST_WAIT;
                    slot_count = 0;
                end
            end
            PH_RST_WAIT: begin
                slot_count++;
                if (slot_count >= us_floor1(timing_us[CFG_PRESENCE_WAIT])) begin
                    bus_phase  = PH_RST_TAIL;
                    slot_count = 0;
                end
            end
            PH_RST_TAIL: begin
                // a device answers by pulling the line low
                if (slot_count == 0) presence_seen = ~line;
                slot_count++;
                if (slot_count >= us_floor1(timing_us[CFG_RESET_TAIL])) begin
                    bus_phase  = PH_IDLE;
                    slot_count = 0;
                    done       = 1'b1;
                end
            end
            PH_WR_LOW: begin
                slot_count++;
                if (slot_count >= tx_low_us()) begin
                    slot_count = 0;
                    if (tx_release_us() == 0) done = close_slot();
                    else bus_phase = PH_WR_REL;
                end
            end
            PH_WR_REL: begin
                slot_count++;
                if (slot_count >= tx_release_us()) done = close_slot();
            end
            PH_RD_LOW: begin
                slot_count++;
                if (slot_count >= us_floor1(timing_us[CFG_READ_LOW])) begin
                    bus_phase  = PH_RD_REL;
                    slot_count = 0;
                end
            end
            PH_RD_REL: begin
                span = us_floor1(timing_us[CFG_READ_SAMPLE]);
                if (slot_count == span) begin
                    if (active_cmd == CMD_RBYTE) shift_byte = {line, shift_byte[7:1]};
                    else shift_byte = {7'd0, line};
                end
                slot_count++;
                if (slot_count >= span + ReadTailUs) done = close_slot();
            end
            default: ;
        endcase

        res.done_res  = done;
        res.presence  = presence_seen;
        res.read_data = (active_cmd == CMD_RBYTE || active_cmd == CMD_RBIT) ? shift_byte : '0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output flow control
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("drive_low", want.drive_low, out_ch.drive_low);
                check_field("busy_res", want.busy_res, out_ch.busy_res);
                check_field("done_res", want.done_res, out_ch.done_res);
                check_field("presence", want.presence, out_ch.presence);
                check_field("read_data", want.read_data, out_ch.read_data);
            end
        end
    end

    initial begin : drive_result_ready
        int unsigned hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holdoff_req != 0) begin
                hold_left   = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("one_wire_bus_master_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic pick_line(input t_line_style style);
        case (style)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick(input logic [2:0] mode, input logic [7:0] data, input logic line);
        while (!steady_flow && $urandom_range(0, 99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.data_byte  <= data;
        in_ch.line_level <= line;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_bus_tick(mode, data, line));
        ticks_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainSlack) @(posedge i_clk);
    endtask

    task automatic load_timing(input t_timing_set plan);
        drain_results();
        i_cfg_we <= 1'b1;
        for (int i = 0; i < CfgCount; i++) begin
            i_cfg_index  <= CfgIdxW'(i);
            i_cfg_data   <= plan[i];
            timing_us[i] = plan[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Keep ticking until the command in flight completes; modes sent meanwhile are ignored.
    task automatic finish_command(input t_line_style style);
        while (bus_phase != PH_IDLE)
            send_tick(3'($urandom_range(0, 7)), 8'($urandom), pick_line(style));
    endtask

    task automatic run_command(input logic [2:0] mode, input logic [7:0] data,
                               input t_line_style style);
        send_tick(mode, data, pick_line(style));
        finish_command(style);
    endtask

    function automatic logic [CfgWidth-1:0] random_us();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 12) return CfgWidth'($urandom_range(13, 40));
        return CfgWidth'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_timing();
        send_tick(CMD_NONE, 8'hFF, 1'b0);
        send_tick(MODE_SPARE_A, 8'h00, 1'b1);
        send_tick(MODE_SPARE_B, 8'hFF, 1'b0);
        run_command(CMD_RBIT, 8'hFF, LINE_LOW);
    endtask

    task automatic test_timing_extremes();
        t_timing_set plan;
        plan = '{default: 10'd1};
        plan[CFG_WRITE_SLOT] = 10'd2;
        load_timing(plan);
        run_command(CMD_RESET, 8'h00, LINE_LOW);
        run_command(CMD_WBYTE, 8'hFF, LINE_NOISY);
        run_command(CMD_RESET, 8'h00, LINE_HIGH);

        // zero everywhere: each phase length falls back to one microsecond, and the write release is skipped
        plan = '{default: '0};
        load_timing(plan);
        run_command(CMD_RESET, 8'h00, LINE_NOISY);
        run_command(CMD_WBYTE, 8'h96, LINE_NOISY);
    endtask

    task automatic test_low_fills_slot();
        t_timing_set plan;
        plan = '{10'd8, 10'd4, 10'd6, 10'd3, 10'd5, 10'd3, 10'd2, 10'd3};
        load_timing(plan);
        run_command(CMD_WBYTE, 8'h5A, LINE_NOISY);
    endtask

    task automatic test_retime_mid_command();
        t_timing_set plan;
        plan = '{10'd1023, 10'd4, 10'd10, 10'd4, 10'd8, 10'd12, 10'd6, 10'd1023};
        load_timing(plan);

        // cut the reset low phase below the time it has already run
        send_tick(CMD_RESET, 8'h00, 1'b1);
        repeat (20) send_tick(CMD_NONE, 8'h00, 1'b1);
        plan[CFG_RESET_LOW] = 10'd5;
        load_timing(plan);
        finish_command(LINE_LOW);

        // move the sample point behind the current count, skipping the sample
        send_tick(CMD_RBIT, 8'h00, 1'b1);
        repeat (12) send_tick(CMD_NONE, 8'h00, pick_line(LINE_NOISY));
        plan[CFG_READ_SAMPLE] = 10'd2;
        load_timing(plan);
        finish_command(LINE_NOISY);

        // shrink the slot under the low time during the second bit of a byte
        send_tick(CMD_WBYTE, 8'h3C, 1'b1);
        repeat (15) send_tick(CMD_NONE, 8'h00, 1'b1);
        plan[CFG_WRITE_SLOT] = 10'd3;
        load_timing(plan);
        finish_command(LINE_NOISY);
    endtask

    task automatic test_output_hold_off();
        t_timing_set plan;
        plan = '{10'd6, 10'd3, 10'd5, 10'd2, 10'd7, 10'd10, 10'd1, 10'd2};
        load_timing(plan);
        // no gaps on either side once the hold-off ends
        steady_flow = 1'b1;
        holdoff_req = HoldOffCycles;
        run_command(CMD_RBYTE, 8'h00, LINE_NOISY);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        t_timing_set plan;
        int unsigned start;
        int unsigned round;
        logic [2:0]  mode;
        start = ticks_sent;
        round = 0;
        while (ticks_sent - start < RandomTicks) begin
            if (round % 4 == 0) begin
                foreach (plan[i]) plan[i] = random_us();
                load_timing(plan);
            end
            mode = 3'($urandom_range(0, 7));
            // a byte read runs for hundreds of ticks; read a single bit here
            if (mode == CMD_RBYTE) mode = CMD_RBIT;
            if (mode >= CMD_RESET && mode <= CMD_RBIT) begin
                run_command(mode, 8'($urandom),
                            ($urandom_range(0, 9) == 0) ? LINE_HIGH : LINE_NOISY);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_tick(mode, 8'($urandom), pick_line(LINE_NOISY));
            end
            round++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_RESET_LOW;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = CMD_NONE;
        in_ch.data_byte  = '0;
        in_ch.line_level = 1'b1;
        ticks_sent       = 0;
        fail_count       = 0;
        steady_flow      = 1'b0;
        holdoff_req      = 0;
        reset_bus_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_timing_extremes();
        test_low_fills_slot();
        test_retime_mid_command();
        test_output_hold_off();
        test_random_traffic();

        drain_results();
        if (fail_count == 0) begin
            $display("one_wire_bus_master_top: match");
        end else begin
            $display("one_wire_bus_master_top: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/owb_pkg.sv
hw/rtl/owb_if.sv
hw/rtl/owb_front.sv
hw/rtl/owb_engine.sv
hw/rtl/one_wire_bus_master_top.sv
tb/one_wire_bus_master_top_test.sv
